// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the block clock, off while reset is held.
`define PFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define PFC_ASSERT_IMPL(label, ante, cons, msg) \
  `PFC_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/pfc_pkg.sv =====
`default_nettype none

package pfc_pkg;

  localparam int GridDim    = 5;
  localparam int Cells      = GridDim * GridDim;
  localparam int NumLetters = 26;

  typedef logic [4:0] letter_t;  // letter index, A = 0
  typedef logic [4:0] cell_t;    // square cell, row-major
  typedef logic [2:0] coord_t;   // row or column

  localparam letter_t LetI = 5'd8;
  localparam letter_t LetJ = 5'd9;
  localparam letter_t LetQ = 5'd16;
  localparam letter_t LetX = 5'd23;
  localparam letter_t LetZ = 5'd25;

  localparam logic [7:0] ChUpA  = 8'h41;
  localparam logic [7:0] ChUpZ  = 8'h5A;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowZ = 8'h7A;
  localparam logic [7:0] CaseOffset = 8'h20;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_KPLACE,
    S_FILL,
    S_TEVAL,
    S_PRD,
    S_PSQ,
    S_POUT1,
    S_POUT2
  } state_e;

  typedef enum logic [1:0] {
    PS_LET,
    PS_FILLER,
    PS_PAD
  } pair_sel_e;

  typedef enum logic [1:0] {
    OK_ERR,
    OK_FIRST,
    OK_SECOND
  } out_kind_e;

  typedef struct packed {
    logic      latch_in;
    logic      key_start;
    logic      key_place;
    logic      fill_step;
    logic      hold_let;
    logic      pair_rd;
    logic      clr_held;
    logic      sq_rd;
    logic      out_load;
    out_kind_e out_kind;
    logic      out_last;
    pair_sel_e pair_sel;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic last;
    logic key_loading;
    logic held_valid;
    logic is_letter;
    logic same;
    logic walk_done;
    logic out_free;
  } sts_t;

  // Cell of a letter in the plain square; J shares the cell of I.
  function automatic cell_t reset_pos(letter_t l);
    reset_pos = (l >= LetJ) ? cell_t'(l - 5'd1) : cell_t'(l);
  endfunction

  // Letter in a cell of the plain square.
  function automatic letter_t reset_sq(cell_t c);
    reset_sq = (c >= cell_t'(LetJ)) ? letter_t'(c + 5'd1) : letter_t'(c);
  endfunction

  function automatic coord_t cell_row(cell_t p);
    coord_t r;
    r = '0;
    for (int k = 1; k < GridDim; k++) begin
      if (int'(p) >= k * GridDim) r = coord_t'(k);
    end
    cell_row = r;
  endfunction

  function automatic coord_t cell_col(cell_t p);
    cell_col = coord_t'(int'(p) - int'(cell_row(p)) * GridDim);
  endfunction

  function automatic cell_t cell_idx(coord_t r, coord_t c);
    cell_idx = cell_t'(int'(r) * GridDim + int'(c));
  endfunction

  // Move one place along a row or column with wrap; back when dec is set.
  function automatic coord_t coord_step(coord_t v, logic dec);
    if (dec) coord_step = (v == '0) ? coord_t'(GridDim - 1) : coord_t'(v - 3'd1);
    else     coord_step = (v == coord_t'(GridDim - 1)) ? '0 : coord_t'(v + 3'd1);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pfc_ctrl.sv =====
`default_nettype none

module pfc_ctrl
  import pfc_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e    state_q, state_d;
  pair_sel_e sel_q, sel_d;
  logic      final_q, final_d;
  logic      pad_q, pad_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= PS_LET;
      final_q <= 1'b0;
      pad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      final_q <= final_d;
      pad_q   <= pad_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    final_d    = final_q;
    pad_d      = pad_q;
    cmd_o      = '0;
    cmd_o.pair_sel = sel_q;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!sts_i.mode) begin
          cmd_o.key_start = !sts_i.key_loading;
          state_d = S_KPLACE;
        end else begin
          state_d = sts_i.key_loading ? S_FILL : S_TEVAL;
        end
      end
      S_KPLACE: begin
        cmd_o.key_place = 1'b1;
        state_d = sts_i.last ? S_FILL : S_IDLE;
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.walk_done) state_d = sts_i.mode ? S_TEVAL : S_IDLE;
      end
      S_TEVAL: begin
        if (!sts_i.is_letter) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = OK_ERR;
            cmd_o.out_last = !(sts_i.last && sts_i.held_valid);
            if (sts_i.last && sts_i.held_valid) begin
              sel_d = PS_PAD; final_d = 1'b1; pad_d = 1'b0;
              state_d = S_PRD;
            end else begin
              state_d = S_IDLE;
            end
          end
        end else if (!sts_i.held_valid) begin
          cmd_o.hold_let = 1'b1;
          if (sts_i.last) begin
            sel_d = PS_PAD; final_d = 1'b1; pad_d = 1'b0;
            state_d = S_PRD;
          end else begin
            state_d = S_IDLE;
          end
        end else if (sts_i.same) begin
          // doubled letter: filler pair, the letter stays held
          sel_d = PS_FILLER; final_d = !sts_i.last; pad_d = sts_i.last;
          state_d = S_PRD;
        end else begin
          sel_d = PS_LET; final_d = 1'b1; pad_d = 1'b0;
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        cmd_o.pair_rd  = 1'b1;
        cmd_o.clr_held = (sel_q != PS_FILLER);
        state_d = S_PSQ;
      end
      S_PSQ: begin
        cmd_o.sq_rd = 1'b1;
        state_d = S_POUT1;
      end
      S_POUT1: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = OK_FIRST;
          state_d = S_POUT2;
        end
      end
      S_POUT2: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = OK_SECOND;
          cmd_o.out_last = final_q;
          if (pad_q) begin
            sel_d = PS_PAD; final_d = 1'b1; pad_d = 1'b0;
            state_d = S_PRD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pfc_datapath.sv =====
`default_nettype none

module pfc_datapath
  import pfc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  wire        in_mode_i,
  input  wire  [7:0] in_byte_i,
  input  wire        in_last_i,
  input  wire        cfg_we_i,
  input  wire        cfg_decrypt_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [6:0] out_letter_o,
  output logic       out_last_o,
  output logic       out_error_o
);

  // latched item
  logic       mode_q, last_q;
  logic [7:0] byte_q;

  logic                  decrypt_q;
  logic [NumLetters-1:0] seen_q;
  cell_t                 fill_q;
  logic                  key_loading_q;
  logic                  keyed_q;
  letter_t               held_q;
  logic                  held_valid_q;
  letter_t               walk_q;

  letter_t sq_mem  [Cells];
  cell_t   pos_mem [NumLetters];

  cell_t   pa_q, pb_q;
  letter_t la_q, lb_q;

  logic       out_valid_q, out_last_q, out_err_q;
  logic [6:0] out_letter_q;

  logic [7:0] key_up, key_diff, txt_diff;
  logic       key_is_let, txt_is_let;
  letter_t    key_let, txt_let, op_b, place_let;
  logic       place_en, do_place, walk_done, out_free;
  coord_t     r1, c1, r2, c2, nr1, nc1, nr2, nc2;
  cell_t      ia, ib;

  function automatic logic in_range(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
    in_range = (v >= lo) && (v <= hi);
  endfunction

  always_comb begin
    key_up     = (in_range(byte_q, ChLowA, ChLowZ)) ? byte_q - CaseOffset : byte_q;
    key_is_let = in_range(key_up, ChUpA, ChUpZ);
    key_diff   = key_up - ChUpA;
    key_let    = (letter_t'(key_diff[4:0]) == LetJ) ? LetI : letter_t'(key_diff[4:0]);
    txt_is_let = in_range(byte_q, ChUpA, ChUpZ);
    txt_diff   = byte_q - ChUpA;
    txt_let    = (letter_t'(txt_diff[4:0]) == LetJ) ? LetI : letter_t'(txt_diff[4:0]);
  end

  always_comb begin
    place_en  = 1'b0;
    place_let = walk_q;
    if (cmd_i.key_place) begin
      place_en  = key_is_let;
      place_let = key_let;
    end else if (cmd_i.fill_step) begin
      place_en  = (walk_q != LetJ);
    end
    do_place  = place_en && !seen_q[place_let] && (fill_q < cell_t'(Cells));
    walk_done = cmd_i.fill_step && (walk_q == letter_t'(NumLetters - 1));
  end

  always_comb begin
    case (cmd_i.pair_sel)
      PS_LET:    op_b = txt_let;
      PS_FILLER: op_b = (held_q == LetX) ? LetQ : LetX;
      default:   op_b = LetZ;
    endcase
  end

  // digraph rule on the two registered cells
  always_comb begin
    r1 = cell_row(pa_q);
    c1 = cell_col(pa_q);
    r2 = cell_row(pb_q);
    c2 = cell_col(pb_q);
    nr1 = r1; nc1 = c1; nr2 = r2; nc2 = c2;
    if (r1 == r2) begin
      nc1 = coord_step(c1, decrypt_q);
      nc2 = coord_step(c2, decrypt_q);
    end else if (c1 == c2) begin
      nr1 = coord_step(r1, decrypt_q);
      nr2 = coord_step(r2, decrypt_q);
    end else begin
      nc1 = c2;
      nc2 = c1;
    end
    ia = cell_idx(nr1, nc1);
    ib = cell_idx(nr2, nc2);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      mode_q <= in_mode_i;
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  // square and position stores; until the first key ends they read as the plain square
  always_ff @(posedge clk_i) begin
    if (do_place) begin
      sq_mem[fill_q]     <= place_let;
      pos_mem[place_let] <= fill_q;
    end
    if (cmd_i.pair_rd) begin
      pa_q <= keyed_q ? pos_mem[held_q] : reset_pos(held_q);
      pb_q <= keyed_q ? pos_mem[op_b]   : reset_pos(op_b);
    end
    if (cmd_i.sq_rd) begin
      la_q <= keyed_q ? sq_mem[ia] : reset_sq(ia);
      lb_q <= keyed_q ? sq_mem[ib] : reset_sq(ib);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q     <= 1'b0;
      seen_q        <= '0;
      fill_q        <= '0;
      key_loading_q <= 1'b0;
      keyed_q       <= 1'b0;
      held_q        <= '0;
      held_valid_q  <= 1'b0;
      walk_q        <= '0;
    end else begin
      if (cfg_we_i) decrypt_q <= cfg_decrypt_i;
      if (cmd_i.latch_in) walk_q <= '0;
      if (cmd_i.key_start) begin
        seen_q        <= '0;
        fill_q        <= '0;
        held_q        <= '0;
        held_valid_q  <= 1'b0;
        key_loading_q <= 1'b1;
      end
      if (do_place) begin
        seen_q[place_let] <= 1'b1;
        fill_q            <= fill_q + 5'd1;
      end
      if (cmd_i.fill_step) begin
        walk_q <= walk_q + 5'd1;
        if (walk_done) begin
          key_loading_q <= 1'b0;
          keyed_q       <= 1'b1;
        end
      end
      if (cmd_i.hold_let) begin
        held_q       <= txt_let;
        held_valid_q <= 1'b1;
      end
      if (cmd_i.clr_held) held_valid_q <= 1'b0;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_last_q <= cmd_i.out_last;
      out_err_q  <= (cmd_i.out_kind == OK_ERR);
      case (cmd_i.out_kind)
        OK_FIRST:  out_letter_q <= 7'(la_q) + 7'(ChUpA);
        OK_SECOND: out_letter_q <= 7'(lb_q) + 7'(ChUpA);
        default:   out_letter_q <= '0;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_letter_o = out_letter_q;
  assign out_last_o   = out_last_q;
  assign out_error_o  = out_err_q;

  always_comb begin
    sts_o.mode        = mode_q;
    sts_o.last        = last_q;
    sts_o.key_loading = key_loading_q;
    sts_o.held_valid  = held_valid_q;
    sts_o.is_letter   = txt_is_let;
    sts_o.same        = (txt_let == held_q);
    sts_o.walk_done   = walk_done;
    sts_o.out_free    = out_free;
  end

endmodule

`default_nettype wire

// ===== rtl/playfair_cipher_engine.sv =====
// Channel   Dir  tdata             tuser    tlast
// s_axis    in   in_byte[7:0]      mode     in_last
// m_axis    out  out_letter[6:0]   out_err  out_last
// cfg       in   decrypt[0]        -        -
//
// An item is taken one at a time. A key byte is dispatched and placed; a key end
// adds a walk over the alphabet to complete the square. A text letter is either
// only held or closes a pair: a read of both positions, then a read of both square
// cells, then each output letter in turn through the output register. Both stores
// reset by a flag, not by a clearing pass. The output register stalls the
// sequencer only while a result waits on m_axis_tready.
`default_nettype none

module playfair_cipher_engine
  import pfc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire        s_axis_tlast,
  input  wire        s_axis_tuser,   // [0] mode
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_letter, [7] zero
  output logic       m_axis_tlast,
  output logic       m_axis_tuser,   // [0] out_error
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire        cfg_data_i      // [0] decrypt
);

  cmd_t       cmd;
  sts_t       sts;
  logic [6:0] letter;

  assign cfg_ready_o = 1'b1;

  pfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_mode_i     (s_axis_tuser),
    .in_byte_i     (s_axis_tdata),
    .in_last_i     (s_axis_tlast),
    .cfg_we_i      (cfg_valid_i),
    .cfg_decrypt_i (cfg_data_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_letter_o  (letter),
    .out_last_o    (m_axis_tlast),
    .out_error_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, letter};

endmodule

`default_nettype wire

// ===== rtl/pfc_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module pfc_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       m_axis_tvalid,
  input wire       m_axis_tready,
  input wire [7:0] m_axis_tdata,
  input wire       m_axis_tlast,
  input wire       m_axis_tuser
);

  `PFC_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser)), "result changed while stalled")
  `PFC_ASSERT_IMPL(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 8'h00, "error item carries a letter")
  `PFC_ASSERT_IMPL(a_letter_range, m_axis_tvalid && !m_axis_tuser, (m_axis_tdata >= 8'h41) && (m_axis_tdata <= 8'h5A), "letter outside A to Z")

endmodule

bind playfair_cipher_engine pfc_checker u_pfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pfc_pkg::*;

  localparam logic ModeKey  = 1'b0;
  localparam logic ModeText = 1'b1;
  localparam int   DrainCycles = 40;  // key end walk plus output pipe

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
    logic       err;
  } res_t;

  // one stimulus row; n_fixed > 0 gives the results typed in the row
  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       last;
    logic [1:0] n_fixed;
    logic [7:0] t0;
    logic       e0;
    logic [7:0] t1;
    logic       e1;
  } row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_data_i;

  playfair_cipher_engine DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // cipher state kept alongside the block
  letter_t              sq_let [Cells];
  cell_t                pos_of [NumLetters];
  logic [NumLetters-1:0] seen_mask;
  int                   fill_n;
  logic                 key_on;
  letter_t              held;
  logic                 held_ok;
  logic                 dec_mode;

  res_t item_letters [$];
  res_t letters_due [$];

  int   fails;
  logic calm;
  int   n_key, n_text, n_checked, n_err_res;

  row_t dir_tab [25] = '{
    '{ModeText, "A",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeText, "B",   1'b0, 2'd2, "B",  1'b0, "C",  1'b0},
    '{ModeText, 8'h00, 1'b0, 2'd1, 8'd0, 1'b1, 8'd0, 1'b0},
    '{ModeText, 8'hFF, 1'b1, 2'd1, 8'd0, 1'b1, 8'd0, 1'b0},
    '{ModeText, "Z",   1'b1, 2'd2, "V",  1'b0, "V",  1'b0},
    '{ModeText, "J",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeText, "I",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeText, "a",   1'b1, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeText, "X",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeText, "X",   1'b1, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeText, "A",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeText, "F",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeText, "M",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeKey,  "p",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeKey,  "L",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeKey,  "a",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeKey,  "y",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeKey,  "-",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeKey,  "j",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeKey,  "Z",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeText, "H",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeText, "I",   1'b1, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeKey,  "1",   1'b0, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeKey,  8'h80, 1'b1, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{ModeText, "W",   1'b1, 2'd0, 8'd0, 1'b0, 8'd0, 1'b0}
  };

  function automatic void plain_square();
    int p;
    p = 0;
    for (int l = 0; l < NumLetters; l++) begin
      if (letter_t'(l) != LetJ) begin
        sq_let[p] = letter_t'(l);
        pos_of[l] = cell_t'(p);
        p++;
      end
    end
    pos_of[LetJ] = pos_of[LetI];
  endfunction

  function automatic void place(letter_t l);
    if (seen_mask[l] || fill_n >= Cells) return;
    seen_mask[l] = 1'b1;
    sq_let[fill_n] = l;
    pos_of[l] = cell_t'(fill_n);
    fill_n++;
  endfunction

  function automatic void close_square();
    for (int l = 0; l < NumLetters; l++) begin
      if (letter_t'(l) != LetJ) place(letter_t'(l));
    end
    pos_of[LetJ] = pos_of[LetI];
    key_on = 1'b0;
  endfunction

  function automatic letter_t to_letter(logic [7:0] ch);
    letter_t l;
    l = letter_t'(ch - ChUpA);
    return (l == LetJ) ? LetI : l;
  endfunction

  function automatic logic [6:0] cell_char(int r, int c);
    return 7'(int'(sq_let[r * GridDim + c]) + int'(ChUpA));
  endfunction

  // substitute one digraph: same row, same column, else rectangle
  function automatic void code_pair(letter_t a, letter_t b);
    int r1, c1, r2, c2, t, stp;
    r1 = int'(pos_of[a]) / GridDim;
    c1 = int'(pos_of[a]) % GridDim;
    r2 = int'(pos_of[b]) / GridDim;
    c2 = int'(pos_of[b]) % GridDim;
    stp = dec_mode ? GridDim - 1 : 1;
    if (r1 == r2) begin
      c1 = (c1 + stp) % GridDim;
      c2 = (c2 + stp) % GridDim;
    end else if (c1 == c2) begin
      r1 = (r1 + stp) % GridDim;
      r2 = (r2 + stp) % GridDim;
    end else begin
      t = c1;
      c1 = c2;
      c2 = t;
    end
    item_letters.push_back('{cell_char(r1, c1), 1'b0, 1'b0});
    item_letters.push_back('{cell_char(r2, c2), 1'b0, 1'b0});
  endfunction

  function automatic void cipher_item(logic m, logic [7:0] b, logic l);
    logic [7:0] ch;
    letter_t    cur_let;
    item_letters.delete();
    ch = b;
    if (m == ModeKey) begin
      if (!key_on) begin
        // new key: forget the old square and any held text letter
        seen_mask = '0;
        fill_n = 0;
        held_ok = 1'b0;
        held = '0;
        key_on = 1'b1;
      end
      if (ch >= ChLowA && ch <= ChLowZ) ch = ch - CaseOffset;
      if (ch >= ChUpA && ch <= ChUpZ) place(to_letter(ch));
      if (l) close_square();
      return;
    end
    if (key_on) close_square();
    if (ch >= ChUpA && ch <= ChUpZ) begin
      cur_let = to_letter(ch);
      if (!held_ok) begin
        held = cur_let;
        held_ok = 1'b1;
      end else if (cur_let == held) begin
        code_pair(held, (held == LetX) ? LetQ : LetX);
      end else begin
        code_pair(held, cur_let);
        held_ok = 1'b0;
      end
    end else begin
      item_letters.push_back('{7'd0, 1'b0, 1'b1});
    end
    if (l && held_ok) begin
      code_pair(held, LetZ);
      held_ok = 1'b0;
    end
    if (item_letters.size() > 0) item_letters[item_letters.size() - 1].last = 1'b1;
  endfunction

  function automatic int pause();
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic row_t mk(logic m, logic [7:0] b, logic l);
    row_t r;
    r = '0;
    r.mode = m;
    r.data = b;
    r.last = l;
    return r;
  endfunction

  function automatic logic [7:0] key_char();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return ChUpA + 8'($urandom_range(0, 25));
    if (p < 80) return ChLowA + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] text_char(logic [7:0] prev);
    int p;
    p = $urandom_range(0, 99);
    if (p < 18 && prev >= ChUpA && prev <= ChUpZ) return prev;  // doubled letter
    if (p < 26) return "X";
    if (p < 31) return "J";
    if (p < 35) return ChLowA + 8'($urandom_range(0, 25));
    if (p < 40) return 8'($urandom_range(0, 255));
    return ChUpA + 8'($urandom_range(0, 25));
  endfunction

  task automatic feed(input row_t r);
    int gap;
    gap = pause();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.data;
    s_axis_tuser  <= r.mode;
    s_axis_tlast  <= r.last;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    cipher_item(r.mode, r.data, r.last);
    if (r.n_fixed == 0) begin
      foreach (item_letters[k]) letters_due.push_back(item_letters[k]);
    end else begin
      letters_due.push_back('{r.t0[6:0], r.n_fixed == 2'd1, r.e0});
      if (r.n_fixed == 2'd2) letters_due.push_back('{r.t1[6:0], 1'b1, r.e1});
    end
    if (r.mode == ModeKey) n_key++;
    else n_text++;
  endtask

  // hold until every result is in, then give the key walk time to finish
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (letters_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_decrypt(input logic v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    dec_mode = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(input int target);
    int         n, len;
    logic       broken;
    logic [7:0] ch, prev;
    n = 0;
    while (n < target) begin
      calm = ($urandom_range(0, 3) == 0);
      broken = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) < 3) begin
        len = $urandom_range(0, 7);
        for (int k = 0; k <= len; k++) begin
          feed(mk(ModeKey, key_char(), (k == len) && !broken));
          n++;
        end
      end else begin
        len = $urandom_range(1, 9);
        prev = 8'h00;
        for (int k = 1; k <= len; k++) begin
          ch = text_char(prev);
          feed(mk(ModeText, ch, (k == len) && !broken));
          prev = ch;
          n++;
        end
      end
    end
    calm = 1'b0;
  endtask

  // result side: random stalls, compare each item with the oldest expectation
  initial begin
    int   gap;
    res_t want;
    m_axis_tready = 1'b0;
    forever begin
      gap = pause();
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (m_axis_tvalid !== 1'b1) @(posedge clk_i);
      n_checked++;
      if (m_axis_tuser === 1'b1) n_err_res++;
      if (letters_due.size() == 0) begin
        $display("%0t: unexpected result tdata %h tlast %b tuser %b", $time,
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
        fails++;
      end else begin
        want = letters_due.pop_front();
        if (m_axis_tdata !== {1'b0, want.letter}) begin
          $display("%0t: out_letter expected %h got %h", $time, {1'b0, want.letter},
                   m_axis_tdata);
          fails++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: out_last expected %b got %b", $time, want.last, m_axis_tlast);
          fails++;
        end
        if (m_axis_tuser !== want.err) begin
          $display("%0t: out_error expected %b got %b", $time, want.err, m_axis_tuser);
          fails++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = ModeKey;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 1'b0;
    calm          = 1'b0;
    fails         = 0;
    n_key         = 0;
    n_text        = 0;
    n_checked     = 0;
    n_err_res     = 0;
    plain_square();
    seen_mask = '0;
    fill_n    = 0;
    key_on    = 1'b0;
    held      = '0;
    held_ok   = 1'b0;
    dec_mode  = 1'b0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_decrypt(1'b0);
    foreach (dir_tab[i]) feed(dir_tab[i]);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      set_decrypt((ph == 1) ? 1'b0 : 1'b1);
      random_phase(50);
      drain();
    end

    $display("covered %0d key items and %0d text items, encrypt and decrypt", n_key, n_text);
    $display("checked %0d results, %0d of them error results", n_checked, n_err_res);
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
